@@ rtl/rc6bd_pkg.sv @@
// Shared types and constants for the RC6 block decryption engine.
package rc6bd_pkg;

    // Key schedule magic constants
    localparam logic [31:0] P32 = 32'hB7E15163;
    localparam logic [31:0] Q32 = 32'h9E3779B9;

    // Key register file geometry
    localparam int NUM_KEY_REGS = 8;
    localparam int CFG_AW       = 5;

    // Command opcodes
    localparam logic OP_EXPAND  = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Response status codes
    localparam logic [1:0] STATUS_PLAIN = 2'd0;
    localparam logic [1:0] STATUS_KEYED = 2'd1;
    localparam logic [1:0] STATUS_NOKEY = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [31:0] cipher_a;
        logic [31:0] cipher_b;
        logic [31:0] cipher_c;
        logic [31:0] cipher_d;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] plain_a;
        logic [31:0] plain_b;
        logic [31:0] plain_c;
        logic [31:0] plain_d;
    } rsp_t;

endpackage

@@ rtl/rc6bd_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module rc6bd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr0,
    output logic [WIDTH-1:0]         rd_data0,
    input  logic [$clog2(DEPTH)-1:0] rd_addr1,
    output logic [WIDTH-1:0]         rd_data1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register both reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

@@ rtl/rc6_block_decrypt_top.sv @@
// RC6-32 block decryption engine with on-chip key schedule: top level.
//
// The block holds eight 32-bit key registers on an APB-style port and runs one
// command at a time. An expand command runs the RC6 key schedule: the round keys
// start from P32 stepped by Q32 on the first lap, and 3*max(KEY_WORDS,
// 2*ROUNDS+4) mixing passes follow through the shared adder and rotator; an
// expand returns status 1. In a decrypt round the quadratic mix products are
// registered before the subtract-rotate-xor step reads the round key pair. A
// decrypt before any expand goes straight to the final state and returns
// status 2. The final state waits while an earlier beat is still stalled.
// Plaintext words read zero unless status is 0. The round keys live in
// a dual-read RAM; no clearing pass is needed. The response sits in an output
// register, so a new command is taken while the previous beat still waits on
// rsp_stall.
module rc6_block_decrypt_top #(
    parameter int ROUNDS    = 20,
    parameter int KEY_WORDS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  rc6bd_pkg::cmd_t        cmd,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rc6bd_pkg::rsp_t        rsp,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [rc6bd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    import rc6bd_pkg::*;

    localparam int NRK    = 2 * ROUNDS + 4;
    localparam int PASSES = 3 * ((KEY_WORDS > NRK) ? KEY_WORDS : NRK);
    localparam int RK_AW  = $clog2(NRK);
    localparam int S_W    = $clog2(PASSES);
    localparam int KJ_W   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int RND_W  = $clog2(ROUNDS + 1);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_EXP_A    = 8'b0000_0010,
        ST_EXP_B    = 8'b0000_0100,
        ST_DEC_PRE  = 8'b0000_1000,
        ST_DEC_MUL  = 8'b0001_0000,
        ST_DEC_ROT  = 8'b0010_0000,
        ST_DEC_POST = 8'b0100_0000,
        ST_FIN      = 8'b1000_0000
    } state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    // Control state
    state_t            state_reg, state_next;
    logic              key_ready_reg, key_ready_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [31:0]       key_reg [NUM_KEY_REGS];

    // Working registers
    logic [31:0]       a_reg, a_next;
    logic [31:0]       b_reg, b_next;
    logic [31:0]       c_reg, c_next;
    logic [31:0]       d_reg, d_next;
    logic [31:0]       pa_reg, pa_next;
    logic [31:0]       pc_reg, pc_next;
    logic [31:0]       init_reg, init_next;
    logic [31:0]       ks_reg [KEY_WORDS];
    logic [31:0]       ks_next [KEY_WORDS];
    logic [RK_AW-1:0]  ri_reg, ri_next;
    logic [KJ_W-1:0]   kj_reg, kj_next;
    logic [S_W-1:0]    s_reg, s_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [1:0]        status_reg, status_next;
    rsp_t              rsp_reg, rsp_next;

    // RAM hookup
    logic              ram_wr_en;
    logic [RK_AW-1:0]  ram_rd_addr0, ram_rd_addr1;
    logic [31:0]       ram_rd_data0, ram_rd_data1;

    // Datapath intermediates
    logic              cmd_fire;
    logic              cfg_write;
    logic              first_lap;
    logic [31:0]       src_rk;
    logic [31:0]       sum_ab;
    logic [31:0]       mix_t, mix_u;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = key_reg[paddr[CFG_AW-1:2]];
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign first_lap = (s_reg < S_W'(NRK));
    assign src_rk    = first_lap ? init_reg : ram_rd_data0;
    assign sum_ab    = a_reg + b_reg;
    assign mix_t     = rotl32(pa_reg, 5'd5);
    assign mix_u     = rotl32(pc_reg, 5'd5);
    assign ram_wr_en = (state_reg == ST_EXP_A);

    rc6bd_ram #(
        .WIDTH (32),
        .DEPTH (NRK)
    ) u_rk_ram (
        .clk      (clk),
        .wr_en    (ram_wr_en),
        .wr_addr  (ri_reg),
        .wr_data  (a_next),
        .rd_addr0 (ram_rd_addr0),
        .rd_data0 (ram_rd_data0),
        .rd_addr1 (ram_rd_addr1),
        .rd_data1 (ram_rd_data1)
    );

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        key_ready_next = key_ready_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        pa_next        = pa_reg;
        pc_next        = pc_reg;
        init_next      = init_reg;
        ks_next        = ks_reg;
        ri_next        = ri_reg;
        kj_next        = kj_reg;
        s_next         = s_reg;
        rnd_next       = rnd_reg;
        status_next    = status_reg;
        ram_rd_addr0   = '0;
        ram_rd_addr1   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.opcode == OP_EXPAND)
                    begin
                        // Load scratch key words, start the mixing passes
                        for (int k = 0; k < KEY_WORDS; k++)
                        begin
                            ks_next[k] = key_reg[k];
                        end
                        a_next     = '0;
                        b_next     = '0;
                        ri_next    = '0;
                        kj_next    = '0;
                        s_next     = '0;
                        init_next  = P32;
                        state_next = ST_EXP_A;
                    end
                    else if (!key_ready_reg)
                    begin
                        status_next = STATUS_NOKEY;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        // Fetch the input whitening keys
                        a_next       = cmd.cipher_a;
                        b_next       = cmd.cipher_b;
                        c_next       = cmd.cipher_c;
                        d_next       = cmd.cipher_d;
                        rnd_next     = RND_W'(ROUNDS);
                        ram_rd_addr0 = RK_AW'(NRK - 2);
                        ram_rd_addr1 = RK_AW'(NRK - 1);
                        state_next   = ST_DEC_PRE;
                    end
                end
            end

            ST_EXP_A:
            begin
                // Mix the round key word and write it back
                a_next     = rotl32(src_rk + a_reg + b_reg, 5'd3);
                state_next = ST_EXP_B;
            end

            ST_EXP_B:
            begin
                // Mix the scratch key word, advance both indexes
                b_next         = rotl32(ks_reg[kj_reg] + sum_ab, sum_ab[4:0]);
                ks_next[kj_reg] = b_next;
                ri_next        = (ri_reg == RK_AW'(NRK - 1)) ? '0 : ri_reg + 1'b1;
                kj_next        = (kj_reg == KJ_W'(KEY_WORDS - 1)) ? '0 : kj_reg + 1'b1;
                s_next         = s_reg + 1'b1;
                init_next      = init_reg + Q32;
                ram_rd_addr0   = ri_next;
                if (s_reg == S_W'(PASSES - 1))
                begin
                    key_ready_next = 1'b1;
                    status_next    = STATUS_KEYED;
                    state_next     = ST_FIN;
                end
                else
                begin
                    state_next = ST_EXP_A;
                end
            end

            ST_DEC_PRE:
            begin
                c_next     = c_reg - ram_rd_data1;
                a_next     = a_reg - ram_rd_data0;
                state_next = ST_DEC_MUL;
            end

            ST_DEC_MUL:
            begin
                // Register the quadratic products, fetch this round's keys
                pa_next      = a_reg * {a_reg[30:0], 1'b1};
                pc_next      = c_reg * {c_reg[30:0], 1'b1};
                ram_rd_addr0 = RK_AW'({rnd_reg, 1'b0});
                ram_rd_addr1 = RK_AW'({rnd_reg, 1'b1});
                state_next   = ST_DEC_ROT;
            end

            ST_DEC_ROT:
            begin
                // Undo one round with the word rotation folded in
                a_next   = rotr32(d_reg - ram_rd_data0, mix_u[4:0]) ^ mix_t;
                c_next   = rotr32(b_reg - ram_rd_data1, mix_t[4:0]) ^ mix_u;
                b_next   = a_reg;
                d_next   = c_reg;
                rnd_next = rnd_reg - 1'b1;
                if (rnd_reg == RND_W'(1))
                begin
                    ram_rd_addr0 = RK_AW'(0);
                    ram_rd_addr1 = RK_AW'(1);
                    state_next   = ST_DEC_POST;
                end
                else
                begin
                    state_next = ST_DEC_MUL;
                end
            end

            ST_DEC_POST:
            begin
                d_next      = d_reg - ram_rd_data1;
                b_next      = b_reg - ram_rd_data0;
                status_next = STATUS_PLAIN;
                state_next  = ST_FIN;
            end

            ST_FIN:
            begin
                // Hand the result to the output register once it is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status = status_reg;
                    if (status_reg == STATUS_PLAIN)
                    begin
                        rsp_next.plain_a = a_reg;
                        rsp_next.plain_b = b_reg;
                        rsp_next.plain_c = c_reg;
                        rsp_next.plain_d = d_reg;
                    end
                    else
                    begin
                        rsp_next.plain_a = '0;
                        rsp_next.plain_b = '0;
                        rsp_next.plain_c = '0;
                        rsp_next.plain_d = '0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_ready_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_KEY_REGS; k++)
            begin
                key_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            key_ready_reg <= key_ready_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                key_reg[paddr[CFG_AW-1:2]] <= pwdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        pa_reg     <= pa_next;
        pc_reg     <= pc_next;
        init_reg   <= init_next;
        ks_reg     <= ks_next;
        ri_reg     <= ri_next;
        kj_reg     <= kj_next;
        s_reg      <= s_next;
        rnd_reg    <= rnd_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

`ifndef SYNTHESIS
    // An accepted command always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> (state_reg != ST_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // Plaintext is only delivered once a key has been expanded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && status_reg == STATUS_PLAIN) |-> key_ready_reg)
        else $error("plaintext result without an expanded key");

    // Round counter stays in range while decrypting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC_MUL || state_reg == ST_DEC_ROT)
            |-> (rnd_reg >= RND_W'(1) && rnd_reg <= RND_W'(ROUNDS)))
        else $error("round counter out of range");

    // Round key index stays inside the store during the schedule
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXP_A || state_reg == ST_EXP_B) |-> (ri_reg < RK_AW'(NRK)))
        else $error("round key index out of range");

    // A response never carries an undefined status code
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == STATUS_PLAIN || rsp.status == STATUS_KEYED
                       || rsp.status == STATUS_NOKEY))
        else $error("response status code undefined");
`endif

endmodule
